// ----- hw/rtl/grbr_pkg.sv -----
// Shared types, constants and pattern helpers for the glyph row bitplane renderer.
// No dependencies; used by glyph_row_bitplane_renderer_core.
package grbr_pkg;

    // Request commands
    localparam logic [1:0] CMD_RENDER = 2'd0;
    localparam logic [1:0] CMD_DEFINE = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FOREGROUND = 2'd0;
    localparam logic [1:0] REG_BACKGROUND = 2'd1;
    localparam logic [1:0] REG_WIDE       = 2'd2;

    localparam logic [6:0] FOREGROUND_RESET = 7'd7;
    localparam logic [6:0] BACKGROUND_RESET = 7'd0;

    // Character code map
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] DELETE_CODE     = 8'h7F;
    localparam logic [7:0] SOLID_FIRST     = 8'h80;
    localparam logic [7:0] USER_FIRST      = 8'hE0;
    localparam logic [7:0] SOLID_ROW       = 8'hFF;

    localparam int FONT_ENTRIES = 760;
    localparam int FONT_AW      = 10;

    typedef enum logic [1:0] {
        SRC_FONT,
        SRC_SOLID,
        SRC_USER
    } src_t;

    // each pixel of the nibble becomes two adjacent bits
    function automatic logic [7:0] double_nibble(input logic [3:0] nib);
        logic [7:0] res;
        for (int i = 0; i < 4; i++)
        begin
            res[2*i]   = nib[i];
            res[2*i+1] = nib[i];
        end
        return res;
    endfunction

    // Equal color bits give a solid byte; otherwise pass or invert the pattern.
    function automatic logic [7:0] map_plane(input logic [7:0] pattern,
                                             input logic fg, input logic bg);
        logic [7:0] res;
        priority if (fg == bg)
        begin
            res = {8{fg}};
        end
        else if (fg)
        begin
            res = pattern;
        end
        else
        begin
            res = ~pattern;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/glyph_row_bitplane_renderer_core.sv -----
// Top level of the 8x8 text mode glyph row bitplane renderer.
// Holds the font and user glyph stores, the fetch stage and the result register.
// Depends on grbr_pkg.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  request   | req_valid / req_ready | cmd, char_code, glyph_row, plane, row_pattern
//  result    | rsp_valid / rsp_ready | first_byte, second_byte, second_valid, drawn
//  config    | APB psel / penable    | paddr, pwdata, prdata, pready (always high)
//
// One request per cycle sustained while rsp_ready is high. The store read is registered
// in the fetch stage, then the color map is registered into the result register. Reset
// clears the user glyph store at once through per-entry valid bits; the font store holds
// garbage until loaded. With rsp_ready low the result holds, one more request is taken
// into the fetch stage, then req_ready drops.
module glyph_row_bitplane_renderer_core #(
    parameter int USER_GLYPHS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [2:0]  glyph_row,
    input  logic [2:0]  plane,
    input  logic [7:0]  row_pattern,

    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic        second_valid,
    output logic        drawn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int UOFF_W       = $clog2(USER_GLYPHS);
    localparam int USER_ENTRIES = USER_GLYPHS * 8;
    localparam int USER_AW      = UOFF_W + 3;

    // ---------------- configuration ----------------
    logic [6:0] fg_reg;
    logic [6:0] bg_reg;
    logic       wide_reg;
    logic       cfg_write;
    logic [1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg   <= grbr_pkg::FOREGROUND_RESET;
            bg_reg   <= grbr_pkg::BACKGROUND_RESET;
            wide_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                grbr_pkg::REG_FOREGROUND: fg_reg   <= pwdata[6:0];
                grbr_pkg::REG_BACKGROUND: bg_reg   <= pwdata[6:0];
                grbr_pkg::REG_WIDE:       wide_reg <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            grbr_pkg::REG_FOREGROUND: prdata = {25'd0, fg_reg};
            grbr_pkg::REG_BACKGROUND: prdata = {25'd0, bg_reg};
            grbr_pkg::REG_WIDE:       prdata = {31'd0, wide_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic advance;
    logic req_accept;

    assign advance    = !rsp_valid_reg || rsp_ready;
    assign req_ready  = advance || !s1_valid_reg;
    assign req_accept = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ---------------- request decode ----------------
    logic                       is_user_code;
    logic                       is_font_code;
    logic                       is_drawable;
    logic [7:0]                 user_sub;
    logic [7:0]                 font_sub;
    logic [USER_AW-1:0]         user_idx;
    logic [grbr_pkg::FONT_AW-1:0] font_idx;
    logic                       user_wr;
    logic                       font_wr;
    grbr_pkg::src_t             src;

    assign is_user_code = char_code >= grbr_pkg::USER_FIRST;
    assign is_font_code = (char_code >= grbr_pkg::FIRST_PRINTABLE)
                       && (char_code <  grbr_pkg::DELETE_CODE);
    assign is_drawable  = (char_code >= grbr_pkg::FIRST_PRINTABLE)
                       && (char_code != grbr_pkg::DELETE_CODE);
    assign user_sub     = char_code - grbr_pkg::USER_FIRST;
    assign font_sub     = char_code - grbr_pkg::FIRST_PRINTABLE;
    assign user_idx     = {user_sub[UOFF_W-1:0], glyph_row};
    assign font_idx     = {font_sub[6:0], glyph_row};
    assign user_wr      = req_accept && (cmd == grbr_pkg::CMD_DEFINE) && is_user_code;
    assign font_wr      = req_accept && (cmd == grbr_pkg::CMD_LOAD) && is_font_code;

    always_comb
    begin
        priority if (is_user_code)
        begin
            src = grbr_pkg::SRC_USER;
        end
        else if (char_code >= grbr_pkg::SOLID_FIRST)
        begin
            src = grbr_pkg::SRC_SOLID;
        end
        else
        begin
            src = grbr_pkg::SRC_FONT;
        end
    end

    // ---------------- glyph stores ----------------
    logic [7:0]              font_mem [grbr_pkg::FONT_ENTRIES];
    logic [7:0]              user_mem [USER_ENTRIES];
    logic [USER_ENTRIES-1:0] user_vld_reg;
    logic [7:0]              font_rd_reg;
    logic [7:0]              user_rd_reg;
    logic                    user_vld_rd_reg;

    always_ff @(posedge clk)
    begin
        if (font_wr)
        begin
            font_mem[font_idx] <= row_pattern;
        end
        if (req_accept)
        begin
            font_rd_reg <= font_mem[font_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (user_wr)
        begin
            user_mem[user_idx] <= row_pattern;
        end
        if (req_accept)
        begin
            user_rd_reg     <= user_mem[user_idx];
            user_vld_rd_reg <= user_vld_reg[user_idx];
        end
    end

    // a row never defined since reset reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_vld_reg <= '0;
        end
        else if (user_wr)
        begin
            user_vld_reg[user_idx] <= 1'b1;
        end
    end

    // ---------------- fetch stage ----------------
    logic           s1_drawn_reg;
    grbr_pkg::src_t s1_src_reg;
    logic [2:0]     s1_plane_reg;

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_drawn_reg <= (cmd == grbr_pkg::CMD_RENDER) && is_drawable;
            s1_src_reg   <= src;
            s1_plane_reg <= plane;
        end
    end

    // ---------------- map into result ----------------
    logic [7:0] pixels;
    logic [7:0] fg_ext;
    logic [7:0] bg_ext;
    logic       fg_bit;
    logic       bg_bit;
    logic [7:0] first_byte_reg;
    logic [7:0] first_byte_next;
    logic [7:0] second_byte_reg;
    logic [7:0] second_byte_next;
    logic       second_valid_reg;
    logic       second_valid_next;
    logic       drawn_reg;

    // plane seven reads a color bit that is always zero
    assign fg_ext = {1'b0, fg_reg};
    assign bg_ext = {1'b0, bg_reg};
    assign fg_bit = fg_ext[s1_plane_reg];
    assign bg_bit = bg_ext[s1_plane_reg];

    always_comb
    begin
        unique case (s1_src_reg)
            grbr_pkg::SRC_USER:  pixels = user_vld_rd_reg ? user_rd_reg : 8'h00;
            grbr_pkg::SRC_SOLID: pixels = grbr_pkg::SOLID_ROW;
            grbr_pkg::SRC_FONT:  pixels = font_rd_reg;
            default:             pixels = 8'h00;
        endcase
    end

    always_comb
    begin
        first_byte_next   = 8'h00;
        second_byte_next  = 8'h00;
        second_valid_next = 1'b0;
        if (s1_drawn_reg)
        begin
            if (wide_reg)
            begin
                first_byte_next   = grbr_pkg::map_plane(
                    grbr_pkg::double_nibble(pixels[7:4]), fg_bit, bg_bit);
                second_byte_next  = grbr_pkg::map_plane(
                    grbr_pkg::double_nibble(pixels[3:0]), fg_bit, bg_bit);
                second_valid_next = 1'b1;
            end
            else
            begin
                first_byte_next = grbr_pkg::map_plane(pixels, fg_bit, bg_bit);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            first_byte_reg   <= first_byte_next;
            second_byte_reg  <= second_byte_next;
            second_valid_reg <= second_valid_next;
            drawn_reg        <= s1_drawn_reg;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign first_byte   = first_byte_reg;
    assign second_byte  = second_byte_reg;
    assign second_valid = second_valid_reg;
    assign drawn        = drawn_reg;

    // ---------------- assertions ----------------
    a_fetch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("fetch stage lost a request while the result was stalled");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !req_ready)
        else $error("request taken with both stages full");

    a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !drawn) |->
            (first_byte == 8'h00) && (second_byte == 8'h00) && !second_valid)
        else $error("result without drawing carries nonzero fields");

    a_fetch_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> rsp_valid)
        else $error("fetched request did not reach the result register");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for glyph_row_bitplane_renderer_core: directed and random requests,
// with a cycle-free predictor of the font/user stores and the color map.
// Depends on grbr_pkg and the core RTL.
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] code;
        logic [2:0] row;
        logic [2:0] plane_sel;
        logic [7:0] pattern;
    } glyph_request_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       second_valid;
        logic       drawn;
    } glyph_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  cmd = grbr_pkg::CMD_RENDER;
    logic [7:0]  char_code = 8'h00;
    logic [2:0]  glyph_row = 3'd0;
    logic [2:0]  plane = 3'd0;
    logic [7:0]  row_pattern = 8'h00;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        second_valid;
    logic        drawn;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [7:0]    font_rows [grbr_pkg::FONT_ENTRIES];
    logic [7:0]    user_rows [256];
    logic [7:0]    fg_color = {1'b0, grbr_pkg::FOREGROUND_RESET};
    logic [7:0]    bg_color = {1'b0, grbr_pkg::BACKGROUND_RESET};
    logic          wide_mode = 1'b0;
    glyph_result_t pending [$];
    int            mismatch_count = 0;

    // stimulus side: font rows already sent a load, so renders never hit an unwritten row
    bit            font_row_sent [grbr_pkg::FONT_ENTRIES];
    int            font_slots [$];
    bit            steady_flow = 1'b0;
    int            rsp_hold = 0;

    glyph_row_bitplane_renderer_core #(
        .USER_GLYPHS(32)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .char_code   (char_code),
        .glyph_row   (glyph_row),
        .plane       (plane),
        .row_pattern (row_pattern),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .second_valid(second_valid),
        .drawn       (drawn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 clk = ~clk;

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            user_rows[i] = 8'h00;
        end
    end

    function automatic logic [7:0] widen_half(input logic [3:0] nib);
        logic [7:0] w;
        int i;
        for (i = 0; i < 4; i++)
        begin
            w[2*i]   = nib[i];
            w[2*i+1] = nib[i];
        end
        return w;
    endfunction

    // plane 7 sees bit 7 of both colors, always zero
    function automatic logic [7:0] tint_byte(input logic [7:0] pattern,
                                             input logic [2:0] which_plane);
        logic f;
        logic b;
        f = fg_color[which_plane];
        b = bg_color[which_plane];
        if (f == b)
            return {8{f}};
        return f ? pattern : ~pattern;
    endfunction

    function automatic glyph_result_t apply_request(input glyph_request_t r);
        glyph_result_t res;
        logic [7:0] pixels;
        int idx;
        res = '0;
        idx = (int'(r.code) - int'(grbr_pkg::FIRST_PRINTABLE)) * 8 + int'(r.row);
        case (r.op)
            grbr_pkg::CMD_DEFINE:
            begin
                if (r.code >= grbr_pkg::USER_FIRST)
                    user_rows[{r.code[4:0], r.row}] = r.pattern;
            end
            grbr_pkg::CMD_LOAD:
            begin
                if (r.code >= grbr_pkg::FIRST_PRINTABLE && r.code < grbr_pkg::DELETE_CODE)
                    font_rows[idx] = r.pattern;
            end
            grbr_pkg::CMD_RENDER:
            begin
                if (r.code >= grbr_pkg::FIRST_PRINTABLE && r.code != grbr_pkg::DELETE_CODE)
                begin
                    if (r.code >= grbr_pkg::USER_FIRST)
                        pixels = user_rows[{r.code[4:0], r.row}];
                    else if (r.code >= grbr_pkg::SOLID_FIRST)
                        pixels = 8'hFF;
                    else
                        pixels = font_rows[idx];
                    if (wide_mode)
                    begin
                        res.first_byte   = tint_byte(widen_half(pixels[7:4]), r.plane_sel);
                        res.second_byte  = tint_byte(widen_half(pixels[3:0]), r.plane_sel);
                        res.second_valid = 1'b1;
                    end
                    else
                    begin
                        res.first_byte = tint_byte(pixels, r.plane_sel);
                    end
                    res.drawn = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // results are checked before the request of the same edge is predicted
    always @(posedge clk)
    begin : result_monitor
        glyph_request_t seen;
        glyph_result_t  want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending.size() == 0)
                begin
                    mismatch_count++;
                    $error("result with no request outstanding");
                end
                else
                begin
                    want = pending.pop_front();
                    if (first_byte !== want.first_byte)
                    begin
                        mismatch_count++;
                        $error("first_byte: expected %02h, got %02h", want.first_byte, first_byte);
                    end
                    if (second_byte !== want.second_byte)
                    begin
                        mismatch_count++;
                        $error("second_byte: expected %02h, got %02h",
                               want.second_byte, second_byte);
                    end
                    if (second_valid !== want.second_valid)
                    begin
                        mismatch_count++;
                        $error("second_valid: expected %0b, got %0b",
                               want.second_valid, second_valid);
                    end
                    if (drawn !== want.drawn)
                    begin
                        mismatch_count++;
                        $error("drawn: expected %0b, got %0b", want.drawn, drawn);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                seen.op        = cmd;
                seen.code      = char_code;
                seen.row       = glyph_row;
                seen.plane_sel = plane;
                seen.pattern   = row_pattern;
                pending.push_back(apply_request(seen));
            end
        end
    end

    // receiver back-pressure: short random stalls unless flow is held steady
    always @(posedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_hold  <= rsp_hold - 1;
            rsp_ready <= 1'b0;
        end
        else if (!steady_flow && $urandom_range(99) < 2)
        begin
            rsp_hold  <= $urandom_range(3);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic glyph_request_t make_request(input logic [1:0] op, input logic [7:0] code,
                                                    input logic [2:0] row,
                                                    input logic [2:0] which_plane,
                                                    input logic [7:0] pattern);
        glyph_request_t r;
        r.op        = op;
        r.code      = code;
        r.row       = row;
        r.plane_sel = which_plane;
        r.pattern   = pattern;
        return r;
    endfunction

    task automatic send_request(input glyph_request_t r);
        int gap;
        int slot;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 3)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (r.op == grbr_pkg::CMD_LOAD && r.code >= grbr_pkg::FIRST_PRINTABLE
            && r.code < grbr_pkg::DELETE_CODE)
        begin
            slot = (int'(r.code) - int'(grbr_pkg::FIRST_PRINTABLE)) * 8 + int'(r.row);
            if (!font_row_sent[slot])
            begin
                font_row_sent[slot] = 1'b1;
                font_slots.push_back(slot);
            end
        end
        req_valid   <= 1'b1;
        cmd         <= r.op;
        char_code   <= r.code;
        glyph_row   <= r.row;
        plane       <= r.plane_sel;
        row_pattern <= r.pattern;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // stop sending and wait until every outstanding result is back
    task automatic wait_results_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (index)
            grbr_pkg::REG_FOREGROUND: fg_color  = {1'b0, value[6:0]};
            grbr_pkg::REG_BACKGROUND: bg_color  = {1'b0, value[6:0]};
            grbr_pkg::REG_WIDE:       wide_mode = value[0];
            default:
            begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [1:0] index, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
        begin
            mismatch_count++;
            $error("prdata[%0d]: expected %08h, got %08h", index, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_colors(input logic [6:0] fg, input logic [6:0] bg, input logic wide);
        write_register(grbr_pkg::REG_FOREGROUND, {25'd0, fg});
        write_register(grbr_pkg::REG_BACKGROUND, {25'd0, bg});
        write_register(grbr_pkg::REG_WIDE, {31'd0, wide});
        check_register(grbr_pkg::REG_FOREGROUND, {25'd0, fg});
        check_register(grbr_pkg::REG_BACKGROUND, {25'd0, bg});
        check_register(grbr_pkg::REG_WIDE, {31'd0, wide});
    endtask

    function automatic glyph_request_t random_request();
        glyph_request_t r;
        int pick;
        int slot;
        r.op        = grbr_pkg::CMD_RENDER;
        r.code      = 8'($urandom);
        r.row       = 3'($urandom);
        r.plane_sel = 3'($urandom);
        r.pattern   = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            r.op = grbr_pkg::CMD_DEFINE;
            if ($urandom_range(9) != 0)
                r.code[7:5] = 3'b111;
        end
        else if (pick < 35)
        begin
            r.op = grbr_pkg::CMD_LOAD;
            if ($urandom_range(9) != 0)
                r.code = 8'($urandom_range(8'h7E, 8'h20));
        end
        else if (pick < 40)
        begin
            r.op = CMD_UNUSED;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 30 && font_slots.size() > 0)
            begin
                slot   = font_slots[$urandom_range(font_slots.size() - 1)];
                r.code = 8'(int'(grbr_pkg::FIRST_PRINTABLE) + slot / 8);
                r.row  = 3'(slot % 8);
            end
            else if (pick < 55)
            begin
                r.code[7:5] = 3'b111;
            end
            else if (pick < 75)
            begin
                r.code = 8'($urandom_range(8'hDF, 8'h80));
            end
            else if (pick < 90)
            begin
                r.code = ($urandom_range(7) == 0) ? grbr_pkg::DELETE_CODE
                                                   : 8'($urandom_range(31));
            end
            else if (r.code >= grbr_pkg::FIRST_PRINTABLE && r.code < grbr_pkg::DELETE_CODE)
            begin
                // fully random code: steer unloaded font rows into the upper half
                slot = (int'(r.code) - int'(grbr_pkg::FIRST_PRINTABLE)) * 8 + int'(r.row);
                if (!font_row_sent[slot])
                    r.code[7] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic test_reset_state();
        check_register(grbr_pkg::REG_FOREGROUND, {25'd0, grbr_pkg::FOREGROUND_RESET});
        check_register(grbr_pkg::REG_BACKGROUND, {25'd0, grbr_pkg::BACKGROUND_RESET});
        check_register(grbr_pkg::REG_WIDE, 32'd0);
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::SOLID_FIRST,
                                  3'd0, 3'd0, 8'h00));
        // user store is cleared by reset
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::USER_FIRST,
                                  3'd3, 3'd1, 8'hFF));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'h00, 3'd7, 3'd7, 8'hFF));
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::DELETE_CODE,
                                  3'd0, 3'd0, 8'h00));
        wait_results_drained();
    endtask

    task automatic test_store_writes();
        send_request(make_request(grbr_pkg::CMD_LOAD, grbr_pkg::FIRST_PRINTABLE,
                                  3'd0, 3'd0, 8'h81));
        send_request(make_request(grbr_pkg::CMD_LOAD, 8'h7E, 3'd7, 3'd7, 8'h3C));
        // loads outside the printable range are dropped
        send_request(make_request(grbr_pkg::CMD_LOAD, 8'h1F, 3'd0, 3'd0, 8'hFF));
        send_request(make_request(grbr_pkg::CMD_LOAD, grbr_pkg::DELETE_CODE,
                                  3'd7, 3'd0, 8'hFF));
        send_request(make_request(grbr_pkg::CMD_DEFINE, 8'hFF, 3'd7, 3'd0, 8'hA5));
        send_request(make_request(grbr_pkg::CMD_DEFINE, grbr_pkg::USER_FIRST,
                                  3'd0, 3'd0, 8'hFF));
        send_request(make_request(grbr_pkg::CMD_DEFINE, 8'hDF, 3'd0, 3'd0, 8'h55));
        send_request(make_request(CMD_UNUSED, 8'hFF, 3'd7, 3'd7, 8'hFF));
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::FIRST_PRINTABLE,
                                  3'd0, 3'd0, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'h7E, 3'd7, 3'd2, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'hFF, 3'd7, 3'd0, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::USER_FIRST,
                                  3'd0, 3'd1, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'hDF, 3'd0, 3'd0, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'h1F, 3'd5, 3'd0, 8'h00));
        wait_results_drained();
    endtask

    task automatic test_color_planes();
        set_colors(7'd0, 7'd127, 1'b0);
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::SOLID_FIRST,
                                  3'd0, 3'd0, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::FIRST_PRINTABLE,
                                  3'd0, 3'd6, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::FIRST_PRINTABLE,
                                  3'd0, 3'd7, 8'h00));
        wait_results_drained();
        set_colors(7'd127, 7'd127, 1'b0);
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::SOLID_FIRST,
                                  3'd1, 3'd7, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'hFF, 3'd7, 3'd3, 8'h00));
        wait_results_drained();
    endtask

    task automatic test_wide_mode();
        set_colors(7'h55, 7'h2A, 1'b1);
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::FIRST_PRINTABLE,
                                  3'd0, 3'd0, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, grbr_pkg::FIRST_PRINTABLE,
                                  3'd0, 3'd1, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'hFF, 3'd7, 3'd2, 8'h00));
        send_request(make_request(grbr_pkg::CMD_RENDER, 8'h1F, 3'd0, 3'd0, 8'h00));
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_colors(7'd127, 7'd0, 1'b0);
                1:       set_colors(7'd0, 7'd127, 1'b1);
                2:       set_colors(7'd127, 7'd127, 1'b1);
                3:       set_colors(7'd0, 7'd0, 1'b0);
                default: set_colors(7'($urandom), 7'($urandom), 1'($urandom));
            endcase
            // first phase runs with no idling on either side
            steady_flow = (phase == 0);
            for (n = 0; n < 125; n++)
            begin
                send_request(random_request());
                if (phase == 2 && n == 60)
                    wait_results_drained();
            end
            wait_results_drained();
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_store_writes();
        test_color_planes();
        test_wide_mode();
        test_random_traffic();
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (pending.size() != 0)
        begin
            mismatch_count++;
            $error("%0d results never arrived", pending.size());
        end
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/grbr_pkg.sv
hw/rtl/glyph_row_bitplane_renderer_core.sv
verif/testbench.sv
